### rtl/core/hpf2d_pkg.sv
`default_nettype none

package hpf2d_pkg;

  localparam int HPF_MAX_WIDTH  = 2048;
  localparam int HPF_MAX_HALF   = 3;
  localparam int HPF_MAX_HEIGHT = 4096;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam logic [2:0]  RST_KERNEL_SIZE  = 3'd3;
  localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd640;
  localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd480;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] pixel;
  } in_word_t;

  typedef struct packed {
    logic [7:0] filtered;
    logic       frame_last;
  } out_word_t;

  // accumulator control from the sequencer
  typedef struct packed {
    logic clear;
    logic add;
    logic center;
    logic load;
  } acc_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_CALC
  } seq_state_e;

endpackage

`default_nettype wire

### rtl/core/hpf2d_line_store.sv
`default_nettype none

module hpf2d_line_store #(
  parameter int MAX_WIDTH = hpf2d_pkg::HPF_MAX_WIDTH,
  parameter int MAX_HALF  = hpf2d_pkg::HPF_MAX_HALF
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [$clog2((2*MAX_HALF+1)*MAX_WIDTH)-1:0] waddr_i,
  input  wire logic [7:0]                                  wdata_i,
  input  wire logic                                        re_i,
  input  wire logic [$clog2((2*MAX_HALF+1)*MAX_WIDTH)-1:0] raddr_i,
  output logic      [7:0]                                  rdata_o
);

  localparam int DEPTH = (2*MAX_HALF+1)*MAX_WIDTH;

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/hpf2d_acc.sv
`default_nettype none

module hpf2d_acc #(
  parameter int MAX_HALF = hpf2d_pkg::HPF_MAX_HALF
) (
  input  wire logic                            clk_i,
  input  wire hpf2d_pkg::acc_ctl_t             ctl_i,
  input  wire logic [$clog2(MAX_HALF+1)-1:0]   half_i,
  input  wire logic [7:0]                      rdata_i,
  output logic      [7:0]                      filtered_o
);

  localparam int SLOTS = 2*MAX_HALF+1;
  localparam int HW    = $clog2(MAX_HALF+1);
  localparam int KW    = HW+1;
  localparam int SUMW  = $clog2(SLOTS*SLOTS*255+1);

  logic        [SUMW-1:0] acc_q, acc_d;
  logic        [7:0]      center_q;
  logic        [7:0]      res_q, res_d;
  logic        [KW-1:0]   k;
  logic        [SUMW-1:0] prod;
  logic signed [SUMW:0]   val;

  assign k = {half_i, 1'b1};

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clear) begin
      acc_d = '0;
    end else if (ctl_i.add) begin
      acc_d = acc_q + SUMW'(rdata_i);
    end
    prod = SUMW'(k) * SUMW'(k) * SUMW'(center_q);
    val  = $signed({1'b0, prod}) - $signed({1'b0, acc_q});
    if (val < 0) begin
      res_d = 8'd0;
    end else if (val > 255) begin
      res_d = 8'd255;
    end else begin
      res_d = val[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (ctl_i.center) begin
      center_q <= rdata_i;
    end
    if (ctl_i.load) begin
      res_q <= res_d;
    end
  end

  assign filtered_o = res_q;

endmodule

`default_nettype wire

### rtl/core/hpf2d_seq.sv
`default_nettype none

module hpf2d_seq #(
  parameter int MAX_WIDTH  = hpf2d_pkg::HPF_MAX_WIDTH,
  parameter int MAX_HALF   = hpf2d_pkg::HPF_MAX_HALF,
  parameter int MAX_HEIGHT = hpf2d_pkg::HPF_MAX_HEIGHT
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic                                        cfg_valid_i,
  output logic                                             cfg_ready_o,
  input  wire logic [hpf2d_pkg::CFG_IDX_W-1:0]             cfg_index_i,
  input  wire logic [hpf2d_pkg::CFG_DATA_W-1:0]            cfg_data_i,
  input  wire logic                                        in_valid_i,
  output logic                                             in_stall_o,
  input  wire hpf2d_pkg::in_word_t                         in_data_i,
  input  wire logic                                        out_stall_i,
  output logic                                             out_valid_o,
  output logic                                             frame_last_o,
  output logic                                             mem_we_o,
  output logic      [$clog2((2*MAX_HALF+1)*MAX_WIDTH)-1:0] mem_waddr_o,
  output logic      [7:0]                                  mem_wdata_o,
  output logic                                             mem_re_o,
  output logic      [$clog2((2*MAX_HALF+1)*MAX_WIDTH)-1:0] mem_raddr_o,
  output hpf2d_pkg::acc_ctl_t                              acc_ctl_o,
  output logic      [$clog2(MAX_HALF+1)-1:0]               half_o
);

  localparam int SLOTS = 2*MAX_HALF+1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH+1);
  localparam int RW    = $clog2(MAX_HEIGHT+1);
  localparam int SW    = $clog2(SLOTS);
  localparam int HW    = $clog2(MAX_HALF+1);
  localparam int OW    = HW+1;
  localparam int XW    = ((RW > WW) ? RW : WW) + OW + 1;
  localparam int DW    = $clog2(MAX_HALF*MAX_WIDTH+MAX_HALF+2);
  localparam int AW    = $clog2(SLOTS*MAX_WIDTH);
  localparam int LO_W  = (SLOTS > 8) ? SLOTS : 8;
  localparam logic signed [XW-1:0] SLOTS_S = XW'(SLOTS);

  hpf2d_pkg::seq_state_e state_q, state_d;

  logic [2:0]  kernel_q, kernel_d;
  logic [11:0] width_q, width_d;
  logic [12:0] height_q, height_d;

  logic [RW-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [CW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [SW-1:0] in_slot_q, in_slot_d, out_slot_q, out_slot_d;
  logic [DW-1:0] diff_q, diff_d;

  logic signed [OW-1:0] rd_i_q, rd_i_d, rd_j_q, rd_j_d;
  logic                 rd_vld_q, rd_vld_d, rd_ctr_q, rd_ctr_d;
  logic                 out_valid_q, out_valid_d, out_last_q, out_last_d;

  logic [2:0]    kh;
  logic [31:0]   wv, hv;
  logic [HW-1:0] half;
  logic [WW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  logic [DW-1:0] lag;
  logic          in_done;

  logic signed [OW-1:0] half_s, neg_half;
  logic signed [XW-1:0] row_s, rowc_s, d_s, sx, col_s, colc_s, hm1_s, wm1_s;
  logic [SW-1:0]        rslot;
  logic [CW-1:0]        rcol;

  // effective frame geometry
  always_comb begin
    kh = {1'b0, kernel_q[2:1]};
    if (32'(kh) > MAX_HALF) begin
      half = HW'(MAX_HALF);
    end else begin
      half = HW'(kh);
    end
    wv = 32'(width_q);
    if (wv < LO_W) begin
      w_eff = WW'(LO_W);
    end else if (wv > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(wv);
    end
    hv = 32'(height_q);
    if (hv < 1) begin
      h_eff = RW'(1);
    end else if (hv > MAX_HEIGHT) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(hv);
    end
    lag = DW'(half) * DW'(w_eff) + DW'(half) + DW'(1);
  end

  assign half_s   = $signed({1'b0, half});
  assign neg_half = -half_s;
  assign in_done  = (in_row_q >= h_eff);

  // window address with edge replication
  always_comb begin
    hm1_s = XW'(h_eff) - XW'(1);
    wm1_s = XW'(w_eff) - XW'(1);
    row_s = XW'(out_row_q) + XW'(rd_i_q);
    if (row_s < 0) begin
      rowc_s = '0;
    end else if (row_s > hm1_s) begin
      rowc_s = hm1_s;
    end else begin
      rowc_s = row_s;
    end
    d_s = rowc_s - XW'(out_row_q);
    sx  = XW'(out_slot_q) + d_s;
    if (sx < 0) begin
      sx = sx + SLOTS_S;
    end else if (sx >= SLOTS_S) begin
      sx = sx - SLOTS_S;
    end
    rslot = sx[SW-1:0];
    col_s = XW'(out_col_q) + XW'(rd_j_q);
    if (col_s < 0) begin
      colc_s = '0;
    end else if (col_s > wm1_s) begin
      colc_s = wm1_s;
    end else begin
      colc_s = col_s;
    end
    rcol = colc_s[CW-1:0];
  end

  assign mem_raddr_o = AW'(rslot) * AW'(MAX_WIDTH) + AW'(rcol);
  assign mem_waddr_o = AW'(in_slot_q) * AW'(MAX_WIDTH) + AW'(in_col_q);
  assign mem_wdata_o = in_data_i.pixel;

  always_comb begin
    state_d     = state_q;
    kernel_d    = kernel_q;
    width_d     = width_q;
    height_d    = height_q;
    in_row_d    = in_row_q;
    in_col_d    = in_col_q;
    in_slot_d   = in_slot_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_slot_d  = out_slot_q;
    diff_d      = diff_q;
    rd_i_d      = rd_i_q;
    rd_j_d      = rd_j_q;
    rd_vld_d    = 1'b0;
    rd_ctr_d    = 1'b0;
    out_valid_d = out_valid_q;
    out_last_d  = out_last_q;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    acc_ctl_o   = '0;

    acc_ctl_o.add    = rd_vld_q;
    acc_ctl_o.center = rd_vld_q && rd_ctr_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      hpf2d_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.mode == hpf2d_pkg::MODE_PIXEL && !in_done) begin
            mem_we_o = 1'b1;
            if (WW'(in_col_q) + WW'(1) >= w_eff) begin
              in_col_d = '0;
              in_row_d = in_row_q + RW'(1);
              if (in_slot_q == SW'(SLOTS-1)) begin
                in_slot_d = '0;
              end else begin
                in_slot_d = in_slot_q + SW'(1);
              end
            end else begin
              in_col_d = in_col_q + CW'(1);
            end
            if (diff_q + DW'(1) >= lag) begin
              state_d         = hpf2d_pkg::ST_READ;
              rd_i_d          = neg_half;
              rd_j_d          = neg_half;
              acc_ctl_o.clear = 1'b1;
            end else begin
              diff_d = diff_q + DW'(1);
            end
          end else if (in_done) begin
            state_d         = hpf2d_pkg::ST_READ;
            rd_i_d          = neg_half;
            rd_j_d          = neg_half;
            acc_ctl_o.clear = 1'b1;
            diff_d          = diff_q - DW'(1);
          end
        end
      end
      hpf2d_pkg::ST_READ: begin
        mem_re_o = 1'b1;
        rd_vld_d = 1'b1;
        rd_ctr_d = (rd_i_q == '0) && (rd_j_q == '0);
        if (rd_j_q == half_s) begin
          rd_j_d = neg_half;
          if (rd_i_q == half_s) begin
            state_d = hpf2d_pkg::ST_DRAIN;
          end else begin
            rd_i_d = rd_i_q + OW'(1);
          end
        end else begin
          rd_j_d = rd_j_q + OW'(1);
        end
      end
      hpf2d_pkg::ST_DRAIN: begin
        state_d = hpf2d_pkg::ST_CALC;
      end
      hpf2d_pkg::ST_CALC: begin
        if (!out_valid_q || !out_stall_i) begin
          acc_ctl_o.load = 1'b1;
          out_valid_d    = 1'b1;
          out_last_d     = 1'b0;
          state_d        = hpf2d_pkg::ST_IDLE;
          if (WW'(out_col_q) + WW'(1) >= w_eff) begin
            out_col_d = '0;
            if (out_row_q + RW'(1) >= h_eff) begin
              out_last_d = 1'b1;
              in_row_d   = '0;
              in_col_d   = '0;
              in_slot_d  = '0;
              out_row_d  = '0;
              out_slot_d = '0;
              diff_d     = '0;
            end else begin
              out_row_d = out_row_q + RW'(1);
              if (out_slot_q == SW'(SLOTS-1)) begin
                out_slot_d = '0;
              end else begin
                out_slot_d = out_slot_q + SW'(1);
              end
            end
          end else begin
            out_col_d = out_col_q + CW'(1);
          end
        end
      end
      default: begin
        state_d = hpf2d_pkg::ST_IDLE;
      end
    endcase

    // a write to any of the three registers restarts the frame
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hpf2d_pkg::CFG_KERNEL_SIZE:  kernel_d = cfg_data_i[2:0];
        hpf2d_pkg::CFG_IMAGE_WIDTH:  width_d  = cfg_data_i[11:0];
        hpf2d_pkg::CFG_IMAGE_HEIGHT: height_d = cfg_data_i;
        default: ;
      endcase
      if (cfg_index_i == hpf2d_pkg::CFG_KERNEL_SIZE ||
          cfg_index_i == hpf2d_pkg::CFG_IMAGE_WIDTH ||
          cfg_index_i == hpf2d_pkg::CFG_IMAGE_HEIGHT) begin
        in_row_d   = '0;
        in_col_d   = '0;
        in_slot_d  = '0;
        out_row_d  = '0;
        out_col_d  = '0;
        out_slot_d = '0;
        diff_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hpf2d_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_q    <= hpf2d_pkg::RST_KERNEL_SIZE;
      width_q     <= hpf2d_pkg::RST_IMAGE_WIDTH;
      height_q    <= hpf2d_pkg::RST_IMAGE_HEIGHT;
      in_row_q    <= '0;
      in_col_q    <= '0;
      in_slot_q   <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_slot_q  <= '0;
      diff_q      <= '0;
      rd_i_q      <= '0;
      rd_j_q      <= '0;
      rd_vld_q    <= 1'b0;
      rd_ctr_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      kernel_q    <= kernel_d;
      width_q     <= width_d;
      height_q    <= height_d;
      in_row_q    <= in_row_d;
      in_col_q    <= in_col_d;
      in_slot_q   <= in_slot_d;
      out_row_q   <= out_row_d;
      out_col_q   <= out_col_d;
      out_slot_q  <= out_slot_d;
      diff_q      <= diff_d;
      rd_i_q      <= rd_i_d;
      rd_j_q      <= rd_j_d;
      rd_vld_q    <= rd_vld_d;
      rd_ctr_q    <= rd_ctr_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  assign cfg_ready_o  = 1'b1;
  assign in_stall_o   = (state_q != hpf2d_pkg::ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign frame_last_o = out_last_q;
  assign half_o       = half;

endmodule

`default_nettype wire

### rtl/core/high_pass_filter_2d_unit.sv
`default_nettype none

// a word that yields a result stalls the input while its window is read (READ), one
//   window pixel per cycle from the single read port of the line store; the read data
//   drains (DRAIN), the result loads the output register (CALC); others need no read
// a finished result waits in the output register while the next word is taken
// reset: counters clear, registers load k=3, 640x480; line store is not cleared

module high_pass_filter_2d_unit #(
  parameter int MAX_WIDTH  = hpf2d_pkg::HPF_MAX_WIDTH,
  parameter int MAX_HALF   = hpf2d_pkg::HPF_MAX_HALF,
  parameter int MAX_HEIGHT = hpf2d_pkg::HPF_MAX_HEIGHT
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [hpf2d_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [hpf2d_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire hpf2d_pkg::in_word_t              in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output hpf2d_pkg::out_word_t                  out_data_o
);

  localparam int AW = $clog2((2*MAX_HALF+1)*MAX_WIDTH);
  localparam int HW = $clog2(MAX_HALF+1);

  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [7:0]          mem_wdata, mem_rdata;
  hpf2d_pkg::acc_ctl_t acc_ctl;
  logic [HW-1:0]       half;
  logic [7:0]          filtered;
  logic                frame_last;

  hpf2d_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HALF   (MAX_HALF),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .frame_last_o (frame_last),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .acc_ctl_o    (acc_ctl),
    .half_o       (half)
  );

  hpf2d_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HALF  (MAX_HALF)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  hpf2d_acc #(
    .MAX_HALF (MAX_HALF)
  ) u_acc (
    .clk_i      (clk_i),
    .ctl_i      (acc_ctl),
    .half_i     (half),
    .rdata_i    (mem_rdata),
    .filtered_o (filtered)
  );

  assign out_data_o.filtered   = filtered;
  assign out_data_o.frame_last = frame_last;

endmodule

`default_nettype wire

### verif/high_pass_filter_2d_unit_tb.sv
module high_pass_filter_2d_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hpf2d_pkg::*;

  localparam int RING_ROWS     = 2 * HPF_MAX_HALF + 1;
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 1300;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  class hpf_scoreboard;
    bit [7:0] line_mem [RING_ROWS * HPF_MAX_WIDTH];
    int in_row, in_col, out_row, out_col;
    bit [2:0] kernel_reg;
    bit [11:0] width_reg;
    bit [12:0] height_reg;
    out_word_t pending_results [$];
    int accepted;
    int mismatches;

    function new();
      kernel_reg = RST_KERNEL_SIZE;
      width_reg = RST_IMAGE_WIDTH;
      height_reg = RST_IMAGE_HEIGHT;
      accepted = 0;
      mismatches = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      in_row = 0;
      in_col = 0;
      out_row = 0;
      out_col = 0;
    endfunction

    function int half_size();
      int hf = kernel_reg >> 1;
      return (hf > HPF_MAX_HALF) ? HPF_MAX_HALF : hf;
    endfunction

    function int frame_width();
      int lo = (RING_ROWS > 8) ? RING_ROWS : 8;
      int w = width_reg;
      if (w < lo) w = lo;
      if (w > HPF_MAX_WIDTH) w = HPF_MAX_WIDTH;
      return w;
    endfunction

    function int frame_height();
      int h = height_reg;
      if (h < 1) h = 1;
      if (h > HPF_MAX_HEIGHT) h = HPF_MAX_HEIGHT;
      return h;
    endfunction

    // flush words needed after the last pixel of a fresh frame
    function int drain_count();
      int lag = half_size() * frame_width() + half_size();
      int total = frame_width() * frame_height();
      return (lag < total) ? lag : total;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_KERNEL_SIZE: kernel_reg = data[2:0];
        CFG_IMAGE_WIDTH: width_reg = data[11:0];
        CFG_IMAGE_HEIGHT: height_reg = data;
        default: return;
      endcase
      restart_frame();
    endfunction

    function int window_tap(int r, int c, int w, int h);
      if (r < 0) r = 0;
      if (r > h - 1) r = h - 1;
      if (c < 0) c = 0;
      if (c > w - 1) c = w - 1;
      return line_mem[(r % RING_ROWS) * HPF_MAX_WIDTH + c];
    endfunction

    function void emit_filtered(int w, int h, int hf);
      out_word_t res;
      int sum;
      int val;
      int side;
      sum = 0;
      side = 2 * hf + 1;
      for (int i = -hf; i <= hf; i++) begin
        for (int j = -hf; j <= hf; j++) begin
          sum += window_tap(out_row + i, out_col + j, w, h);
        end
      end
      val = side * side * window_tap(out_row, out_col, w, h) - sum;
      if (val < 0) val = 0;
      if (val > 255) val = 255;
      res.filtered = val[7:0];
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
      res.frame_last = (out_row >= h);
      if (res.frame_last) restart_frame();
      pending_results.push_back(res);
    endfunction

    function void note_input(in_word_t word);
      int w = frame_width();
      int h = frame_height();
      int hf = half_size();
      accepted++;
      if (word.mode == MODE_PIXEL && in_row < h) begin
        line_mem[(in_row % RING_ROWS) * HPF_MAX_WIDTH + in_col] = word.pixel;
        in_col++;
        if (in_col >= w) begin
          in_col = 0;
          in_row++;
        end
        if (in_row * w + in_col >= out_row * w + out_col + hf * w + hf + 1) begin
          emit_filtered(w, h, hf);
        end
      end else if (in_row >= h) begin
        emit_filtered(w, h, hf);
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual filtered %0d frame_last %0d",
                 $time, got.filtered, got.frame_last);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.filtered !== want.filtered) begin
        $display("%0t: filtered mismatch, expected %0d actual %0d",
                 $time, want.filtered, got.filtered);
        mismatches++;
      end
      if (got.frame_last !== want.frame_last) begin
        $display("%0t: frame_last mismatch, expected %0d actual %0d",
                 $time, want.frame_last, got.frame_last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_word_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_word_t out_data_o;

  hpf_scoreboard sb;
  in_word_t pixel_words [$];
  int pushed_words = 0;
  int items_sent = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_left = 0;
  int open_left = 0;
  int cycles = 0;
  bit in_fire = 1'b0;

  high_pass_filter_2d_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    in_fire = rst_ni && in_valid_i && !in_stall_o;
    if (in_fire) sb.note_input(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // sender: bursts of words with random gaps
  always @(negedge clk_i) begin
    if (!in_valid_i || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pixel_words.size() != 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= pixel_words.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          if ($urandom_range(0, 99) < gap_pct) gap_left = $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: stall runs between open stretches
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (open_left > 0) begin
        open_left--;
      end else begin
        open_left = $urandom_range(0, 7);
        if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 6);
      end
    end
  end

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void push_word(logic mode, logic [7:0] px);
    pixel_words.push_back({mode, px});
    pushed_words++;
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.apply_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.accepted != pushed_words) @(negedge clk_i);
    while (sb.pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // one whole frame from a fresh start, with random flush words mixed in, then the drain words
  task automatic run_frame(bit edges, int noise_pct, int drain_px_pct);
    int n;
    int drains;
    logic [7:0] px;
    n = sb.frame_width() * sb.frame_height();
    drains = sb.drain_count();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < noise_pct) push_word(MODE_FLUSH, rand_pixel());
      px = edges ? ((i % 2) ? 8'hFF : 8'h00) : rand_pixel();
      push_word(MODE_PIXEL, px);
      items_sent++;
    end
    for (int i = 0; i < drains; i++) begin
      push_word(($urandom_range(0, 99) < drain_px_pct) ? MODE_PIXEL : MODE_FLUSH, rand_pixel());
      items_sent++;
    end
  endtask

  task automatic run_directed();
    // reset config, far from the first result
    push_word(MODE_FLUSH, 8'h00);
    push_word(MODE_PIXEL, 8'hFF);
    push_word(MODE_PIXEL, 8'h00);
    items_sent += 2;
    wait_idle();
    // even kernel, width and height below range, unused index
    cfg_write(CFG_KERNEL_SIZE, 13'd2);
    cfg_write(CFG_IMAGE_WIDTH, 13'd3);
    cfg_write(CFG_IMAGE_HEIGHT, 13'd0);
    cfg_write(CFG_UNUSED, 13'h1FFF);
    push_word(MODE_FLUSH, 8'hFF);
    run_frame(1'b1, 0, 50);
    wait_idle();
    // kernel of one, width and height above range
    cfg_write(CFG_IMAGE_HEIGHT, 13'h1FFF);
    cfg_write(CFG_IMAGE_WIDTH, 13'h0FFF);
    cfg_write(CFG_KERNEL_SIZE, 13'd0);
    push_word(MODE_PIXEL, 8'h00);
    push_word(MODE_PIXEL, 8'hFF);
    push_word(MODE_PIXEL, 8'h5A);
    push_word(MODE_PIXEL, 8'hA5);
    items_sent += 4;
    wait_idle();
  endtask

  task automatic run_random();
    logic [CFG_DATA_W-1:0] data;
    int start;
    int n;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      wait_idle();
      case ($urandom_range(0, 3))
        0: gap_pct = 0;
        1: gap_pct = 15;
        2: gap_pct = 40;
        default: gap_pct = 70;
      endcase
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 15;
        2: stall_pct = 40;
        default: stall_pct = 70;
      endcase
      if ($urandom_range(0, 9) == 0) begin
        // aborted frame under any register values
        repeat ($urandom_range(1, 4)) begin
          cfg_write(CFG_IDX_W'($urandom_range(0, 3)), CFG_DATA_W'($urandom_range(0, 8191)));
        end
        n = $urandom_range(1, 40);
        repeat (n) begin
          push_word(($urandom_range(0, 4) == 0) ? MODE_FLUSH : MODE_PIXEL, rand_pixel());
        end
        items_sent += n;
      end else begin
        data = CFG_DATA_W'($urandom_range(0, 8191));
        data[2:0] = 3'($urandom_range(0, 7));
        cfg_write(CFG_KERNEL_SIZE, data);
        data = CFG_DATA_W'($urandom_range(0, 8191));
        data[11:0] = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 7))
                                                 : 12'($urandom_range(8, 20));
        cfg_write(CFG_IMAGE_WIDTH, data);
        data = ($urandom_range(0, 9) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 10));
        cfg_write(CFG_IMAGE_HEIGHT, data);
        repeat ($urandom_range(1, 3)) run_frame(1'b0, 5, 20);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    run_random();
    wait_idle();
    if (sb.mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
